@@ rtl/color_lightness_replace_defines.svh @@
// Assertion macros shared by the color lightness pipeline.
`ifndef COLOR_LIGHTNESS_REPLACE_DEFINES_SVH
`define COLOR_LIGHTNESS_REPLACE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("color_lightness_replace: property failed");
`define CLR_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("color_lightness_replace: forbidden condition seen");
`else
`define CLR_ASSERT(label, clk, rst, prop)
`define CLR_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/clr_pkg.sv @@
`default_nettype none
package clr_pkg;

   // Fixed point format of lightness, saturation and channel values.
   localparam int FracBits  = 16;
   localparam int FxW       = FracBits + 1;
   localparam int ColorW    = 32;
   localparam int LightW    = 16;
   localparam int ReqDataW  = ColorW + LightW;

   // One saturation quotient bit per divider stage; hue uses the first few.
   localparam int DivStages = FracBits + 1;
   localparam int HueStages = 6;

   // Division by 60 as multiplication by a rounded-up reciprocal.
   localparam int       RecipShift = 28;
   localparam logic [22:0] Recip60 = 23'd4473925;

   // Per-item state while the two divisions run.
   typedef struct packed {
      logic [FxW-1:0]       l_fx;
      logic                 grey;
      logic [7:0]           den;
      logic [23:0]          s_rem;
      logic [DivStages-1:0] s_quo;
      logic [7:0]           dlt;
      logic [13:0]          h_rem;
      logic [5:0]           h_quo;
      logic                 h_neg;
      logic [8:0]           h_base;
   } div_type;

endpackage
`default_nettype wire

@@ rtl/color_lightness_replace.sv @@
// Color lightness replacement, one transaction per clock.
// req channel: tdata carries the packed color (red in the low byte, alpha
// ignored) and the target lightness (value/65535 = 0.0 .. 1.0).
// rsp channel: tdata carries the packed color with the new lightness and
// the alpha byte set to 255, in the same byte order.
// The color goes through RGB to HSL (hue in whole degrees), the lightness
// is replaced, and it comes back through the piecewise hue-to-channel rule.
// Throughput is one transaction per cycle unless rsp_tready stalls it; the
// depth is set by the saturation divider, which resolves one quotient bit
// per stage over 17 stages, with the hue divider running beside it.
// Reset clears all stage valid bits; no transaction is in flight after it.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline holds and req_tready goes low; nothing is lost or repeated.
`default_nettype none
`include "color_lightness_replace_defines.svh"

module color_lightness_replace
   import clr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // [31:0] color_in, [47:32] lightness
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [ColorW-1:0]        rsp_tdata   // [31:0] color_out
);

   logic adv;

   logic              in_vld_ff;
   logic [23:0]       in_rgb_ff;
   logic [LightW-1:0] in_light_ff;

   div_type div_in  [0:DivStages];
   div_type div_ff  [0:DivStages];
   logic    div_vld_ff [0:DivStages];

   logic           fin_vld_ff, fin_grey_ff;
   logic [8:0]     fin_hue_ff, fin_hue_in;
   logic [33:0]    fin_prod_ff;
   logic [FxW-1:0] fin_l_ff, fin_s_ff;

   logic        mix_vld_ff;
   logic [17:0] mix_v1_ff, mix_v2_ff, mix_v1_in, mix_v2_in;
   logic [5:0]  mix_w_ff [3];
   logic [5:0]  mix_w_in [3];

   logic        sp_vld_ff;
   logic [17:0] sp_v1_ff;
   logic [23:0] sp_num_ff [3];

   logic        qo_vld_ff;
   logic [17:0] qo_v1_ff;
   logic [18:0] qo_q_ff [3];
   logic [18:0] qo_q_in [3];

   logic              out_vld_ff;
   logic [ColorW-1:0] out_data_ff, out_data_in;

   // The pipeline moves whenever the output register is free or drained.
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         for (int i = 0; i <= DivStages; i++) div_vld_ff[i] <= 1'b0;
         fin_vld_ff <= 1'b0;
         mix_vld_ff <= 1'b0;
         sp_vld_ff  <= 1'b0;
         qo_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff     <= req_tvalid;
         div_vld_ff[0] <= in_vld_ff;
         for (int i = 1; i <= DivStages; i++) div_vld_ff[i] <= div_vld_ff[i-1];
         fin_vld_ff <= div_vld_ff[DivStages];
         mix_vld_ff <= fin_vld_ff;
         sp_vld_ff  <= mix_vld_ff;
         qo_vld_ff  <= sp_vld_ff;
         out_vld_ff <= qo_vld_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv) begin
         in_rgb_ff   <= req_tdata[23:0];
         in_light_ff <= req_tdata[ColorW +: LightW];
      end
   end

   // Preparation: max, min, saturation divisor and signed hue numerator.
   always_comb begin
      logic [7:0] r, g, b, mx, mn, mag8;
      logic [8:0] sum;
      logic signed [8:0] diff;
      r = in_rgb_ff[7:0];
      g = in_rgb_ff[15:8];
      b = in_rgb_ff[23:16];
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      sum = {1'b0, mx} + {1'b0, mn};
      div_in[0] = '0;
      div_in[0].l_fx = {1'b0, in_light_ff} + FxW'(in_light_ff[LightW-1]);
      div_in[0].grey = (mx == mn);
      div_in[0].den  = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
      div_in[0].dlt  = mx - mn;
      div_in[0].s_rem = {mx - mn, 16'b0} + 24'(div_in[0].den >> 1);
      priority if (r == mx) begin
         diff = $signed({1'b0, g}) - $signed({1'b0, b});
         div_in[0].h_base = 9'd0;
      end else if (g == mx) begin
         diff = $signed({1'b0, b}) - $signed({1'b0, r});
         div_in[0].h_base = 9'd120;
      end else begin
         diff = $signed({1'b0, r}) - $signed({1'b0, g});
         div_in[0].h_base = 9'd240;
      end
      div_in[0].h_neg = diff[8];
      mag8 = diff[8] ? 8'(-diff) : diff[7:0];
      div_in[0].h_rem = (14'(mag8) << 6) - (14'(mag8) << 2);
   end

   // Restoring dividers: one saturation bit per stage, hue bits in the first ones.
   for (genvar j = 0; j < DivStages; j++) begin : g_div
      localparam int  SBit  = DivStages - 1 - j;
      localparam bit  HueOn = (j < HueStages);
      localparam int  HBit  = (j < HueStages) ? (HueStages - 1 - j) : 0;
      always_comb begin
         logic [24:0] s_trial;
         logic [14:0] h_trial;
         div_in[j+1] = div_ff[j];
         s_trial = 25'(div_ff[j].den) << SBit;
         if ({1'b0, div_ff[j].s_rem} >= s_trial) begin
            div_in[j+1].s_rem = 24'({1'b0, div_ff[j].s_rem} - s_trial);
            div_in[j+1].s_quo[SBit] = 1'b1;
         end
         h_trial = 15'(div_ff[j].dlt) << HBit;
         if (HueOn && ({1'b0, div_ff[j].h_rem} >= h_trial)) begin
            div_in[j+1].h_rem = 14'({1'b0, div_ff[j].h_rem} - h_trial);
            div_in[j+1].h_quo[HBit] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= DivStages; i++) div_ff[i] <= div_in[i];
      end
   end

   // Hue: floor of the signed quotient, offset and wrapped to 0..359.
   always_comb begin
      logic signed [7:0]  q;
      logic signed [10:0] h;
      q = $signed({2'b00, div_ff[DivStages].h_quo});
      if (div_ff[DivStages].h_neg) begin
         q = -q - $signed({7'b0, (div_ff[DivStages].h_rem != 14'd0)});
      end
      h = $signed({2'b00, div_ff[DivStages].h_base}) + 11'(q);
      if (h < 0) begin
         h = h + 11'sd360;
      end else if (h >= 11'sd360) begin
         h = h - 11'sd360;
      end
      fin_hue_in = h[8:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_hue_ff  <= fin_hue_in;
         fin_prod_ff <= 34'(div_ff[DivStages].l_fx) * 34'(div_ff[DivStages].s_quo);
         fin_l_ff    <= div_ff[DivStages].l_fx;
         fin_s_ff    <= div_ff[DivStages].s_quo;
         fin_grey_ff <= div_ff[DivStages].grey;
      end
   end

   // Weight of the span at a hue angle, in sixtieths.
   function automatic logic [5:0] hue_weight(input logic [8:0] a);
      priority if (a < 9'd60) return a[5:0];
      else if (a < 9'd180) return 6'd60;
      else if (a < 9'd240) return 6'(9'd240 - a);
      else return 6'd0;
   endfunction

   // Lightness mix: v2 and v1, and the three channel weights.
   always_comb begin
      logic [17:0] ls, lx;
      logic [9:0]  ar, ab;
      ls = 18'((fin_prod_ff + 34'd32768) >> FracBits);
      lx = 18'(fin_l_ff);
      if (fin_l_ff < FxW'(32768)) begin
         mix_v2_in = lx + ls;
      end else begin
         mix_v2_in = lx + 18'(fin_s_ff) - ls;
      end
      mix_v1_in = (lx << 1) - mix_v2_in;
      if (fin_grey_ff) begin
         mix_v1_in = lx;
         mix_v2_in = lx;
      end
      ar = 10'(fin_hue_ff) + 10'd120;
      if (ar >= 10'd360) ar = ar - 10'd360;
      ab = 10'(fin_hue_ff) + 10'd240;
      if (ab >= 10'd360) ab = ab - 10'd360;
      mix_w_in[0] = hue_weight(ar[8:0]);
      mix_w_in[1] = hue_weight(fin_hue_ff);
      mix_w_in[2] = hue_weight(ab[8:0]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mix_v1_ff <= mix_v1_in;
         mix_v2_ff <= mix_v2_in;
         for (int c = 0; c < 3; c++) mix_w_ff[c] <= mix_w_in[c];
      end
   end

   // Span times weight, with the rounding term for the division by 60.
   always_ff @(posedge clock) begin
      if (adv) begin
         sp_v1_ff <= mix_v1_ff;
         for (int c = 0; c < 3; c++) begin
            sp_num_ff[c] <= 24'(mix_v2_ff - mix_v1_ff) * 24'(mix_w_ff[c]) + 24'd30;
         end
      end
   end

   // Division by 60 through the reciprocal.
   always_comb begin
      logic [46:0] p;
      for (int c = 0; c < 3; c++) begin
         p = 47'(sp_num_ff[c]) * 47'(Recip60);
         qo_q_in[c] = 19'(p >> RecipShift);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qo_v1_ff <= sp_v1_ff;
         for (int c = 0; c < 3; c++) qo_q_ff[c] <= qo_q_in[c];
      end
   end

   // Channel value to byte: v*255 rounded, clamped at 255.
   always_comb begin
      logic [18:0] v;
      logic [27:0] t;
      logic [11:0] by;
      out_data_in = {8'hFF, 24'h0};
      for (int c = 0; c < 3; c++) begin
         v  = 19'(qo_v1_ff) + qo_q_ff[c];
         t  = (28'(v) << 8) - 28'(v) + 28'd32768;
         by = t[27:FracBits];
         out_data_in[8*c +: 8] = (by > 12'd255) ? 8'hFF : by[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   // Checks on the internal arithmetic.
   `CLR_ASSERT(a_alpha_set, clock, reset, rsp_tvalid |-> (rsp_tdata[31:24] == 8'hFF))
   `CLR_NEVER(a_sat_range, clock, reset, div_vld_ff[DivStages] && !div_ff[DivStages].grey && (div_ff[DivStages].s_quo > 17'd65536))
   `CLR_NEVER(a_hue_range, clock, reset, fin_vld_ff && (fin_hue_ff >= 9'd360))
   `CLR_NEVER(a_v_order, clock, reset, mix_vld_ff && (mix_v1_ff > mix_v2_ff))
   `CLR_ASSERT(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(qo_vld_ff)))

endmodule
`default_nettype wire
